### rtl/tilemap_scroll_strip_planner_defines.svh
// Assertion macros shared by the tilemap scroll strip planner.
// No dependencies; taken in by the files that carry assertions.
`ifndef TILEMAP_SCROLL_STRIP_PLANNER_DEFINES_SVH
`define TILEMAP_SCROLL_STRIP_PLANNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tss_pkg.sv
// Package for the tilemap scroll strip planner: sizes, constants and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tss_pkg;

    localparam int VIEW_COLS  = 21;
    localparam int VIEW_ROWS  = 16;
    localparam int NUM_PLANES = 2;

    localparam int POS_W = 16;
    localparam int OFF_W = 12;
    localparam int VIEW_MAX = (VIEW_COLS > VIEW_ROWS) ? VIEW_COLS : VIEW_ROWS;
    localparam int CNT_W = $clog2(VIEW_MAX + 1);

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [OFF_W-1:0]        off_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    localparam pos_t VC_POS  = pos_t'(VIEW_COLS);
    localparam pos_t VC_NEG  = pos_t'(-VIEW_COLS);
    localparam pos_t VR_POS  = pos_t'(VIEW_ROWS);
    localparam pos_t VR_NEG  = pos_t'(-VIEW_ROWS);
    localparam pos_t RESET_X = pos_t'(-2 * VIEW_COLS);
    localparam cnt_t VC_CNT  = cnt_t'(VIEW_COLS);
    localparam cnt_t VR_CNT  = cnt_t'(VIEW_ROWS);

    localparam off_t COL_WORDS = off_t'(VIEW_ROWS * 2 * 2);
    localparam off_t ROW_WORDS = off_t'(VIEW_COLS * 2 * 2);

    localparam logic CMD_MOVE  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    typedef struct packed {
        cnt_t col_cnt;
        cnt_t row_cnt;
        logic col_neg;
        logic row_neg;
        cnt_t col_adj;
        cnt_t row_adj;
    } plan_t;

endpackage

### rtl/tss_alu.sv
// Shared 16-bit add/subtract unit of the strip planner.
// Depends on tss_pkg for the position type.
`timescale 1ns / 1ps

module tss_alu (
    input  tss_pkg::pos_t a,
    input  tss_pkg::pos_t b,
    input  logic          sub,
    output tss_pkg::pos_t y
);
    import tss_pkg::*;

    // Positions wrap modulo 2^16, so the carry out is simply dropped.
    assign y = sub ? pos_t'(a - b) : pos_t'(a + b);

endmodule

### rtl/tss_plan.sv
// Classifies a scroll delta into column and row strip counts and start adjustments.
// Depends on tss_pkg for constants and the plan structure.
`timescale 1ns / 1ps

module tss_plan (
    input  tss_pkg::pos_t  dx,
    input  tss_pkg::pos_t  dy,
    output tss_pkg::plan_t plan
);
    import tss_pkg::*;

    pos_t dx_abs;
    pos_t dy_abs;

    assign dx_abs = dx[POS_W-1] ? pos_t'(-dx) : dx;
    assign dy_abs = dy[POS_W-1] ? pos_t'(-dy) : dy;

    always_comb
    begin
        plan.col_neg = dx[POS_W-1];
        plan.row_neg = dy[POS_W-1];
        if (dx > VC_POS || dx < VC_NEG)
        begin
            // A jump wider than the view refetches the whole width only.
            plan.col_cnt = VC_CNT;
            plan.row_cnt = '0;
        end
        else if (dy > VR_POS || dy < VR_NEG)
        begin
            plan.col_cnt = '0;
            plan.row_cnt = VR_CNT;
        end
        else
        begin
            plan.col_cnt = dx_abs[CNT_W-1:0];
            plan.row_cnt = dy_abs[CNT_W-1:0];
        end
        // The first strip lies at the new position plus this small adjustment.
        plan.col_adj = plan.col_neg ? cnt_t'(plan.col_cnt - 1'b1) : cnt_t'(VC_CNT - plan.col_cnt);
        plan.row_adj = plan.row_neg ? cnt_t'(plan.row_cnt - 1'b1) : cnt_t'(VR_CNT - plan.row_cnt);
    end

endmodule

### rtl/tilemap_scroll_strip_planner.sv
// Top level of the tilemap scroll strip planner: sequencer, plane state and output register.
// Depends on tss_pkg, tss_alu, tss_plan and the assertion macro header.
`timescale 1ns / 1ps
`include "tilemap_scroll_strip_planner_defines.svh"

// A move beat first runs set-up on the shared 16-bit adder (two deltas, a classification
// step, two start positions) in S_DX, S_DY, S_PLAN, S_CPOS and S_RPOS, and then issues one
// strip request per cycle in S_EMIT while the output is not stalled; a move emits 1 to 37
// strips. A move that leaves the position unchanged returns to idle from S_PLAN, and a
// frame-start beat is taken in idle without leaving it. Input is stalled while a move is
// in work. An output stall freezes the sequencer in its emit step. The last strip of a
// move may still wait in the output register while the next beat is being set up.
module tilemap_scroll_strip_planner (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          cmd,
    input  logic          plane,
    input  tss_pkg::pos_t new_x,
    input  tss_pkg::pos_t new_y,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          is_row,
    output logic          target_plane,
    output tss_pkg::pos_t strip_x,
    output tss_pkg::pos_t strip_y,
    output tss_pkg::off_t buffer_offset,
    output logic          last
);
    import tss_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DX   = 7'b0000010,
        S_DY   = 7'b0000100,
        S_PLAN = 7'b0001000,
        S_CPOS = 7'b0010000,
        S_RPOS = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    pos_t  last_x_reg [NUM_PLANES];
    pos_t  last_y_reg [NUM_PLANES];
    off_t  staging_reg;
    logic  plane_reg;
    pos_t  nx_reg, ny_reg, cx_reg, cy_reg;
    pos_t  dx_reg, dy_reg;
    pos_t  col_pos_reg, row_pos_reg;
    plan_t plan_reg;
    plan_t plan_comb;

    logic  out_valid_reg;
    logic  is_row_reg, plane_out_reg, last_reg;
    pos_t  strip_x_reg, strip_y_reg;
    off_t  offset_reg;

    pos_t  alu_a, alu_b, alu_y;
    logic  alu_sub;

    logic  in_take;
    logic  emit_load;
    logic  emit_col;
    logic  beat_last;

    tss_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    tss_plan u_plan (
        .dx   (dx_reg),
        .dy   (dy_reg),
        .plan (plan_comb)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign emit_col  = (plan_reg.col_cnt != '0);
    assign beat_last = (plan_reg.col_cnt == '0 && plan_reg.row_cnt == cnt_t'(1))
                    || (plan_reg.col_cnt == cnt_t'(1) && plan_reg.row_cnt == '0);

    always_comb
    begin
        alu_a   = nx_reg;
        alu_b   = cx_reg;
        alu_sub = 1'b1;
        unique case (state_reg)
            S_DX:
            begin
                alu_a   = nx_reg;
                alu_b   = cx_reg;
                alu_sub = 1'b1;
            end
            S_DY:
            begin
                alu_a   = ny_reg;
                alu_b   = cy_reg;
                alu_sub = 1'b1;
            end
            S_CPOS:
            begin
                alu_a   = nx_reg;
                alu_b   = pos_t'(plan_reg.col_adj);
                alu_sub = 1'b0;
            end
            S_RPOS:
            begin
                alu_a   = ny_reg;
                alu_b   = pos_t'(plan_reg.row_adj);
                alu_sub = 1'b0;
            end
            S_EMIT:
            begin
                alu_a   = emit_col ? col_pos_reg : row_pos_reg;
                alu_b   = pos_t'(1);
                alu_sub = emit_col ? plan_reg.col_neg : plan_reg.row_neg;
            end
            default:
            begin
                alu_a   = nx_reg;
                alu_b   = cx_reg;
                alu_sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_take && cmd == CMD_MOVE)
                    state_next = S_DX;
            S_DX:   state_next = S_DY;
            S_DY:   state_next = S_PLAN;
            S_PLAN:
                if (plan_comb.col_cnt == '0 && plan_comb.row_cnt == '0)
                    state_next = S_IDLE;
                else
                    state_next = S_CPOS;
            S_CPOS: state_next = S_RPOS;
            S_RPOS: state_next = S_EMIT;
            S_EMIT:
                if (emit_load && beat_last)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            staging_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                last_x_reg[i] <= RESET_X;
                last_y_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_take)
            begin
                if (cmd == CMD_FRAME)
                    staging_reg <= '0;
                else
                begin
                    // The old position is captured below, so the store can move on now.
                    last_x_reg[plane] <= new_x;
                    last_y_reg[plane] <= new_y;
                end
            end
            else if (emit_load)
                staging_reg <= off_t'(staging_reg + (emit_col ? COL_WORDS : ROW_WORDS));
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            plane_reg <= plane;
            nx_reg    <= new_x;
            ny_reg    <= new_y;
            cx_reg    <= last_x_reg[plane];
            cy_reg    <= last_y_reg[plane];
        end
        if (state_reg == S_DX)
            dx_reg <= alu_y;
        if (state_reg == S_DY)
            dy_reg <= alu_y;
        if (state_reg == S_PLAN)
            plan_reg <= plan_comb;
        if (state_reg == S_CPOS)
            col_pos_reg <= alu_y;
        if (state_reg == S_RPOS)
            row_pos_reg <= alu_y;
        if (emit_load)
        begin
            is_row_reg    <= !emit_col;
            plane_out_reg <= plane_reg;
            strip_x_reg   <= emit_col ? col_pos_reg : nx_reg;
            strip_y_reg   <= emit_col ? ny_reg : row_pos_reg;
            offset_reg    <= staging_reg;
            last_reg      <= beat_last;
            if (emit_col)
            begin
                col_pos_reg      <= alu_y;
                plan_reg.col_cnt <= cnt_t'(plan_reg.col_cnt - 1'b1);
            end
            else
            begin
                row_pos_reg      <= alu_y;
                plan_reg.row_cnt <= cnt_t'(plan_reg.row_cnt - 1'b1);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_row        = is_row_reg;
    assign target_plane  = plane_out_reg;
    assign strip_x       = strip_x_reg;
    assign strip_y       = strip_y_reg;
    assign buffer_offset = offset_reg;
    assign last          = last_reg;

    `TSS_ASSERT_NEXT(a_last_ends_move, clk, rst_n, emit_load && beat_last,
                     state_reg == S_IDLE, "last beat did not end the move")
    `TSS_ASSERT_NOW(a_offset_aligned, clk, rst_n, 1'b1, staging_reg[1:0] == 2'b00,
                    "staging offset lost word alignment")
    `TSS_ASSERT_NOW(a_counts_in_view, clk, rst_n, state_reg == S_EMIT,
                    plan_reg.col_cnt <= VC_CNT && plan_reg.row_cnt <= VR_CNT,
                    "strip count exceeds view size")
    `TSS_ASSERT_NOW(a_emit_has_work, clk, rst_n, state_reg == S_EMIT,
                    plan_reg.col_cnt != '0 || plan_reg.row_cnt != '0,
                    "emitting with no strips left")

endmodule

### dv/tb.sv
// Self-checking testbench for tilemap_scroll_strip_planner: directed table, then random moves.
// Depends on tss_pkg and the planner RTL; expected strips come from a predictor held here.
`timescale 1ns / 1ps

module tb;
    import tss_pkg::*;

    localparam logic PLANE_A     = 1'b0;
    localparam logic PLANE_B     = 1'b1;
    localparam int   RANDOM_MOVES = 500;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   CYCLE_LIMIT  = 1000000;
    localparam int   NUM_OPENING  = 21;

    typedef struct packed {
        logic is_row;
        logic plane;
        pos_t x;
        pos_t y;
        off_t offset;
        logic last;
    } strip_req_t;

    // One row of the opening table; where known is set, the strip count and the
    // first strip are typed in and must agree with the planner model below.
    typedef struct packed {
        logic c;
        logic p;
        pos_t x;
        pos_t y;
        logic known;
        int   n_want;
        logic row_want;
        pos_t x_want;
        pos_t y_want;
        off_t off_want;
    } opening_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic cmd       = 1'b0;
    logic plane     = 1'b0;
    pos_t new_x     = '0;
    pos_t new_y     = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    logic is_row;
    logic target_plane;
    pos_t strip_x;
    pos_t strip_y;
    off_t buffer_offset;
    logic last;

    pos_t       plane_x [NUM_PLANES];
    pos_t       plane_y [NUM_PLANES];
    off_t       stage_off;
    strip_req_t pending_strips [$];
    int         fails        = 0;
    int         cycles       = 0;
    int         burst_left   = 0;
    bit         offering     = 1'b0;
    bit         hold_off_req = 1'b0;

    opening_t opening_moves [NUM_OPENING] = '{
        '{CMD_MOVE,  PLANE_A, -16'sd42,    16'sd0,      1'b1, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_A, -16'sd41,    16'sd0,      1'b1, 1,  1'b0, -16'sd21,    16'sd0,      12'd0},
        '{CMD_FRAME, PLANE_A, 16'sd0,      16'sd0,      1'b1, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_B, -16'sd42,    16'sd1,      1'b1, 1,  1'b1, -16'sd42,    16'sd16,     12'd0},
        '{CMD_MOVE,  PLANE_B, 16'sd58,     16'sd1,      1'b1, 21, 1'b0, 16'sd58,     16'sd1,      12'd84},
        '{CMD_FRAME, PLANE_B, 16'sd0,      16'sd0,      1'b1, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_B, 16'sd58,     16'sd17,     1'b1, 16, 1'b1, 16'sd58,     16'sd17,     12'd0},
        '{CMD_MOVE,  PLANE_B, 16'sd58,     -16'sd983,   1'b1, 16, 1'b1, 16'sd58,     -16'sd968,   12'd1344},
        '{CMD_MOVE,  PLANE_A, 16'sd32767,  16'sd0,      1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_A, 16'sd32762,  16'sd3,      1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_A, -16'sd32768, -16'sd32768, 1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_A, -16'sd32747, -16'sd32752, 1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_A, -16'sd32768, -16'sd32768, 1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_A, -16'sd32747, -16'sd32752, 1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_B, 16'sd58,     -16'sd983,   1'b1, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_B, 16'sd32767,  16'sd32767,  1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_B, -16'sd32768, 16'sd32767,  1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_FRAME, PLANE_B, -16'sd1,     -16'sd1,     1'b1, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_B, -16'sd32768, -16'sd32768, 1'b1, 1,  1'b1, -16'sd32768, -16'sd32753, 12'd0},
        '{CMD_MOVE,  PLANE_A, -16'sd32769, -16'sd32735, 1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0},
        '{CMD_MOVE,  PLANE_A, -16'sd32769, -16'sd32752, 1'b0, 0,  1'b0, 16'sd0,      16'sd0,      12'd0}
    };

    tilemap_scroll_strip_planner u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .plane         (plane),
        .new_x         (new_x),
        .new_y         (new_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_row        (is_row),
        .target_plane  (target_plane),
        .strip_x       (strip_x),
        .strip_y       (strip_y),
        .buffer_offset (buffer_offset),
        .last          (last)
    );

    always #10 clk = ~clk;

    function automatic void add_strip(input logic row, input logic p, input pos_t x,
                                      input pos_t y);
        strip_req_t s;
        s.is_row = row;
        s.plane  = p;
        s.x      = x;
        s.y      = y;
        s.offset = stage_off;
        s.last   = 1'b0;
        pending_strips.push_back(s);
        stage_off = stage_off + (row ? ROW_WORDS : COL_WORDS);
    endfunction

    // Lists the strips a beat brings into view, columns first and then rows,
    // each walking outward from the old edge of the view.
    function automatic int plan_strips(input logic c, input logic p, input pos_t nx,
                                       input pos_t ny);
        pos_t cx;
        pos_t cy;
        pos_t d;
        int   dx;
        int   dy;
        int   n;
        if (c == CMD_FRAME)
        begin
            stage_off = '0;
            return 0;
        end
        cx = plane_x[p];
        cy = plane_y[p];
        d  = nx - cx;
        dx = int'(d);
        d  = ny - cy;
        dy = int'(d);
        if (dx == 0 && dy == 0)
            return 0;
        if (dx > VIEW_COLS)
        begin
            cx = cx + pos_t'(dx - VIEW_COLS);
            dx = VIEW_COLS;
            dy = 0;
        end
        else if (dx < -VIEW_COLS)
        begin
            cx = cx + pos_t'(dx + VIEW_COLS);
            dx = -VIEW_COLS;
            dy = 0;
        end
        else if (dy > VIEW_ROWS)
        begin
            cy = cy + pos_t'(dy - VIEW_ROWS);
            dy = VIEW_ROWS;
            dx = 0;
        end
        else if (dy < -VIEW_ROWS)
        begin
            cy = cy + pos_t'(dy + VIEW_ROWS);
            dy = -VIEW_ROWS;
            dx = 0;
        end
        n = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
        if (dx > 0)
        begin
            cx = cx + pos_t'(VIEW_COLS);
            for (int k = 0; k < dx; k++)
            begin
                add_strip(1'b0, p, cx, ny);
                cx = cx + pos_t'(1);
            end
        end
        else
        begin
            for (int k = 0; k < -dx; k++)
            begin
                cx = cx - pos_t'(1);
                add_strip(1'b0, p, cx, ny);
            end
        end
        if (dy > 0)
        begin
            cy = cy + pos_t'(VIEW_ROWS);
            for (int k = 0; k < dy; k++)
            begin
                add_strip(1'b1, p, nx, cy);
                cy = cy + pos_t'(1);
            end
        end
        else
        begin
            for (int k = 0; k < -dy; k++)
            begin
                cy = cy - pos_t'(1);
                add_strip(1'b1, p, nx, cy);
            end
        end
        if (n > 0)
            pending_strips[pending_strips.size() - 1].last = 1'b1;
        plane_x[p] = nx;
        plane_y[p] = ny;
        return n;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    // Presents one beat and holds it until taken, then predicts its strips and
    // plays out the burst and gap pattern of the sender.
    task automatic offer(input logic c, input logic p, input pos_t nx, input pos_t ny,
                         output int n, output strip_req_t first);
        int gap;
        cmd      <= c;
        plane    <= p;
        new_x    <= nx;
        new_y    <= ny;
        in_valid <= 1'b1;
        offering = 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        n = plan_strips(c, p, nx, ny);
        first = (n > 0) ? pending_strips[pending_strips.size() - n] : '0;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    initial
    begin
        int         n;
        int         r;
        logic       p;
        pos_t       nx;
        pos_t       ny;
        strip_req_t first;
        for (int k = 0; k < NUM_PLANES; k++)
        begin
            plane_x[k] = RESET_X;
            plane_y[k] = '0;
        end
        stage_off = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_moves[i])
        begin
            offer(opening_moves[i].c, opening_moves[i].p, opening_moves[i].x,
                  opening_moves[i].y, n, first);
            if (opening_moves[i].known)
            begin
                check_field("strip count", 16'(opening_moves[i].n_want), 16'(n));
                if (n > 0)
                begin
                    check_field("first is_row", 16'(opening_moves[i].row_want),
                                16'(first.is_row));
                    check_field("first strip_x", opening_moves[i].x_want, first.x);
                    check_field("first strip_y", opening_moves[i].y_want, first.y);
                    check_field("first buffer_offset", 16'(opening_moves[i].off_want),
                                16'(first.offset));
                end
            end
        end

        // The receiver now holds off for a long stretch while moves keep coming.
        hold_off_req = 1'b1;
        for (int i = 0; i < RANDOM_MOVES; i++)
        begin
            r  = $urandom_range(0, 99);
            p  = 1'($urandom);
            nx = plane_x[p];
            ny = plane_y[p];
            if (r < 8)
                offer(CMD_FRAME, p, pos_t'($urandom), pos_t'($urandom), n, first);
            else
            begin
                if (r < 14)
                begin
                    // position left as it is
                end
                else if (r < 82)
                begin
                    nx = nx + pos_t'(int'($urandom_range(0, 50)) - 25);
                    ny = ny + pos_t'(int'($urandom_range(0, 40)) - 20);
                end
                else if (r < 92)
                begin
                    nx = nx + pos_t'(int'($urandom_range(0, 80)) - 40);
                    ny = ny + pos_t'(int'($urandom_range(0, 80)) - 40);
                end
                else
                begin
                    nx = pos_t'($urandom);
                    ny = pos_t'($urandom);
                end
                offer(CMD_MOVE, p, nx, ny, n, first);
            end
        end
        if (offering)
            in_valid <= 1'b0;

        while (pending_strips.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Receiver: stalls on a pattern that changes from one stretch to the next.
    initial
    begin
        int mode;
        int len;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(20, 200);
            for (int k = 0; k < len; k++)
            begin
                @(posedge clk);
                if (hold_off_req)
                begin
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    out_stall <= 1'b0;
                    hold_off_req = 1'b0;
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < 30);
                        2: out_stall <= ($urandom_range(0, 99) < 75);
                        default: out_stall <= (k % 4 != 0);
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        strip_req_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_strips.size() == 0)
            begin
                $error("strip beat with none expected: x %0h y %0h", strip_x, strip_y);
                fails++;
            end
            else
            begin
                want = pending_strips.pop_front();
                check_field("is_row", 16'(want.is_row), 16'(is_row));
                check_field("target_plane", 16'(want.plane), 16'(target_plane));
                check_field("strip_x", want.x, strip_x);
                check_field("strip_y", want.y, strip_y);
                check_field("buffer_offset", 16'(want.offset), 16'(buffer_offset));
                check_field("last", 16'(want.last), 16'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
